/* hw/rtl/sptf_pkg.sv */
// Shared types and constants for the stepper pulse timer with follower.
// No dependencies; used by sptf_core and stepper_pulse_timer_with_follower.
package sptf_pkg;

  localparam logic [14:0] FOLLOWER_CARRY = 15'h4000;
  localparam logic [7:0]  HALF_CYCLE     = 8'd128;

  localparam logic [7:0]  MIN_LOW_RESET  = 8'd10;
  localparam logic [13:0] FOL_INC_RESET  = 14'd528;
  localparam logic        INTERLOCK_RESET = 1'b1;

  typedef enum logic [1:0] {
    MODE_COMPARE = 2'd0,
    MODE_LOAD    = 2'd1,
    MODE_QUEUE   = 2'd2,
    MODE_STOP    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_MIN_LOW   = 2'd0,
    REG_FOL_INC   = 2'd1,
    REG_INTERLOCK = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [7:0]  min_low_count;
    logic [13:0] follower_increment;
    logic        interlock_enable;
  } cfg_t;

  typedef struct packed {
    logic        busy;
    logic [7:0]  full_cycles_left;
    logic        half_pad_pending;
    logic [15:0] remaining_steps;
    logic [15:0] current_period;
    logic [15:0] queued_period;
    logic        period_pending;
    logic [14:0] follower_accum;
  } chan_state_t;

  typedef struct packed {
    logic        step_main;
    logic        step_follower;
    logic [7:0]  compare_advance;
    logic        stopped;
    logic [15:0] steps_left;
  } result_t;

endpackage

/* hw/rtl/stepper_pulse_timer_with_follower.sv */
// Stepper step pulse timer, one channel, with an interlocked follower pulse.
// An accepted event word's result word is loaded into the output register.
// Throughput: 1 event word per cycle unless in_stall; channel state updates in one pass.
// Reset (rst, synchronous): state clears, registers return to 10 / 528 / 1, output empty.
// Config writes are always ready; depends on sptf_pkg and sptf_core.
module stepper_pulse_timer_with_follower (
  input  logic        clk,
  input  logic        rst,
  // event input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [15:0] new_steps,
  input  logic [15:0] period_value,
  // result output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        step_main,
  output logic        step_follower,
  output logic [7:0]  compare_advance,
  output logic        stopped,
  output logic [15:0] steps_left,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  sptf_pkg::cfg_t        cfg;
  sptf_pkg::chan_state_t chan;
  sptf_pkg::chan_state_t chan_next;
  sptf_pkg::result_t     res;
  logic                  in_take;

  // The result register is the only buffer: a new word may enter whenever
  // the register is empty or is being drained this cycle.
  assign in_stall  = out_valid && out_stall;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Configuration registers; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_low_count      <= sptf_pkg::MIN_LOW_RESET;
      cfg.follower_increment <= sptf_pkg::FOL_INC_RESET;
      cfg.interlock_enable   <= sptf_pkg::INTERLOCK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (sptf_pkg::reg_index_t'(cfg_index))
        sptf_pkg::REG_MIN_LOW:   cfg.min_low_count      <= cfg_data[7:0];
        sptf_pkg::REG_FOL_INC:   cfg.follower_increment <= cfg_data;
        sptf_pkg::REG_INTERLOCK: cfg.interlock_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sptf_core u_core (
    .cfg          (cfg),
    .cur          (chan),
    .mode         (mode),
    .new_steps    (new_steps),
    .period_value (period_value),
    .nxt          (chan_next),
    .res          (res)
  );

  // Channel state advances once per accepted event word.
  always_ff @(posedge clk) begin
    if (rst) begin
      chan <= '0;
    end else if (in_take) begin
      chan <= chan_next;
    end
  end

  // Output register: valid is control, the payload loads with it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      step_main       <= res.step_main;
      step_follower   <= res.step_follower;
      compare_advance <= res.compare_advance;
      stopped         <= res.stopped;
      steps_left      <= res.steps_left;
    end
  end

  // A follower pulse only ever rides on a main step.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && step_follower |-> step_main)
    else $error("follower step without main step");

  // Stopped means nothing left to step.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && stopped |-> steps_left == 16'd0)
    else $error("stopped with steps remaining");

  // A compare word that waits may only add the half pad.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !step_main && compare_advance != 8'd0 |-> compare_advance == 8'd128)
    else $error("advance without a step other than half pad");

  // A stop event always reports stopped.
  assert property (@(posedge clk) disable iff (rst)
    in_take && mode == sptf_pkg::MODE_STOP |=> out_valid && stopped)
    else $error("stop event did not stop the channel");

endmodule

/* hw/rtl/sptf_core.sv */
// Single-pass update of one channel: next state and result word for one event.
// Depends on sptf_pkg.
module sptf_core (
  input  sptf_pkg::cfg_t        cfg,
  input  sptf_pkg::chan_state_t cur,
  input  logic [1:0]            mode,
  input  logic [15:0]           new_steps,
  input  logic [15:0]           period_value,
  output sptf_pkg::chan_state_t nxt,
  output sptf_pkg::result_t     res
);

  logic        waited;
  logic [14:0] fol_sum;
  logic [15:0] period_use;
  logic [15:0] min_period;

  always_comb begin
    nxt        = cur;
    res        = '0;
    waited     = 1'b0;
    fol_sum    = cur.follower_accum + {1'b0, cfg.follower_increment};
    period_use = cur.period_pending ? cur.queued_period : cur.current_period;
    min_period = {8'd0, cfg.min_low_count};

    case (sptf_pkg::mode_t'(mode))
      sptf_pkg::MODE_COMPARE: begin
        if (cur.busy) begin
          if (cur.full_cycles_left != 8'd0) begin
            // spend one full 256-tick cycle, finishing any half pad
            nxt.full_cycles_left = cur.full_cycles_left - 8'd1;
            if (cur.half_pad_pending) begin
              res.compare_advance  = sptf_pkg::HALF_CYCLE;
              nxt.half_pad_pending = 1'b0;
            end
            waited = 1'b1;
          end else begin
            nxt.busy = 1'b0;
          end
        end
        if (!waited) begin
          if (cur.remaining_steps != 16'd0) begin
            res.step_main = 1'b1;
            if (cfg.interlock_enable) begin
              nxt.follower_accum = fol_sum & ~sptf_pkg::FOLLOWER_CARRY;
              res.step_follower  = fol_sum[14];
            end
            nxt.period_pending   = 1'b0;
            nxt.current_period   = period_use;
            nxt.remaining_steps  = cur.remaining_steps - 16'd1;
            nxt.busy             = 1'b1;
            nxt.full_cycles_left = period_use[15:8];
            if (period_use[7:0] < cfg.min_low_count) begin
              res.compare_advance  = period_use[7:0] + sptf_pkg::HALF_CYCLE;
              nxt.half_pad_pending = 1'b1;
            end else begin
              res.compare_advance  = period_use[7:0];
              nxt.half_pad_pending = 1'b0;
            end
          end else begin
            nxt.busy = 1'b0;
          end
        end
      end
      sptf_pkg::MODE_LOAD: begin
        nxt.current_period  = (period_value < min_period) ? min_period : period_value;
        nxt.period_pending  = 1'b0;
        if (new_steps == 16'd0) begin
          nxt.busy = 1'b0;
        end
        nxt.remaining_steps = new_steps;
      end
      sptf_pkg::MODE_QUEUE: begin
        nxt.queued_period  = period_value;
        nxt.period_pending = 1'b1;
      end
      default: begin
        nxt.busy            = 1'b0;
        nxt.remaining_steps = 16'd0;
      end
    endcase

    res.stopped    = !nxt.busy && (nxt.remaining_steps == 16'd0);
    res.steps_left = nxt.remaining_steps;
  end

endmodule
